// ===== sv/euler_to_rotation_matrix_top_assert.svh =====
// Assertion macros for the Euler angle to rotation matrix block.
`ifndef EULER_TO_ROTATION_MATRIX_TOP_ASSERT_SVH
`define EULER_TO_ROTATION_MATRIX_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ERTM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define ERTM_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ERTM_ASSERT(lbl, prop)
`define ERTM_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== sv/ertm_pkg.sv =====
// Shared types, constants and arithmetic helpers for the rotation matrix block.
package ertm_pkg;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int DEF_FRAC_BITS     = 14;
    localparam int ATAN_COUNT        = 24;
    localparam int MID_FRAC          = 30;
    localparam int TURN_UNITS        = 46080;
    localparam int HALF_UNITS        = 23040;
    localparam int QUARTER_UNITS     = 11520;
    localparam int ANGLE_SHIFT       = 13;
    localparam int XY_W              = 36;
    localparam int Z_W               = 32;
    localparam int Q_W               = 32;
    localparam int P_W               = 34;
    localparam int FIELD_W           = 16;
    localparam int NUM_OUT           = 9;
    localparam longint KINF_Q40      = 64'sd667681663043;

    localparam logic [26:0] ATAN_Q20 [ATAN_COUNT] = '{
        27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121, 27'd3750058,
        27'd1876857, 27'd938658, 27'd469357, 27'd234682, 27'd117342,
        27'd58671, 27'd29335, 27'd14668, 27'd7334, 27'd3667, 27'd1833,
        27'd917, 27'd458, 27'd229, 27'd115, 27'd57, 27'd29, 27'd14, 27'd7
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   flip;
    } t_lane;

    function automatic logic signed [XY_W-1:0] start_gain(input int n);
        longint g;
        g = KINF_Q40 + (KINF_Q40 >>> (2 * n - 1)) / 3;
        return XY_W'((g + 128) >>> 8);
    endfunction

    function automatic logic signed [P_W-1:0] mulq(input logic signed [Q_W-1:0] a,
                                                    input logic signed [Q_W-1:0] b);
        logic signed [2*Q_W-1:0] p;
        p = a * b;
        return P_W'((p + (64'sd1 <<< (MID_FRAC - 1))) >>> MID_FRAC);
    endfunction
endpackage

// ===== sv/ertm_cordic_cell.sv =====
// One CORDIC rotation cell working on the yaw, pitch and roll lanes together.
module ertm_cordic_cell import ertm_pkg::*; #(
    parameter int SHIFT = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_lane i_lane [3],
    output logic  o_valid,
    input  logic  i_ready,
    output t_lane o_lane [3]
);
    localparam logic signed [Z_W-1:0] ATAN = Z_W'(ATAN_Q20[SHIFT]);

    logic  r_valid;
    t_lane r_lane [3];
    t_lane n_lane [3];

    always_comb begin
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        for (int k = 0; k < 3; k++) begin
            dx = i_lane[k].y >>> SHIFT;
            dy = i_lane[k].x >>> SHIFT;
            n_lane[k].flip = i_lane[k].flip;
            if (i_lane[k].z >= 0) begin
                n_lane[k].x = i_lane[k].x - dx;
                n_lane[k].y = i_lane[k].y + dy;
                n_lane[k].z = i_lane[k].z - ATAN;
            end else begin
                n_lane[k].x = i_lane[k].x + dx;
                n_lane[k].y = i_lane[k].y - dy;
                n_lane[k].z = i_lane[k].z + ATAN;
            end
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_lane  = r_lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lane <= n_lane;
        end
    end
endmodule

// ===== sv/ertm_matrix.sv =====
// Sine and cosine rounding and the four-stage product and sum pipeline for the matrix.
module ertm_matrix import ertm_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  t_lane                         i_lane [3],
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [NUM_OUT-1:0][FIELD_W-1:0] o_fields
);
    localparam int SH = MID_FRAC - FRAC_BITS;
    localparam logic signed [P_W+1:0] RND = (P_W+2)'((64'sd1 <<< SH) >>> 1);
    localparam logic signed [P_W+1:0] LIM = (P_W+2)'(64'sd1 <<< FRAC_BITS);

    function automatic logic [FIELD_W-1:0] to_field(input logic signed [P_W+1:0] v);
        logic signed [P_W+1:0] t;
        t = (v + RND) >>> SH;
        if (t > LIM) begin
            t = LIM;
        end else if (t < -LIM) begin
            t = -LIM;
        end
        return t[FIELD_W-1:0];
    endfunction

    logic r_v0, r_v1, r_v2, r_v3;
    logic w_rdy0, w_rdy1, w_rdy2, w_rdy3;

    logic signed [Q_W-1:0] r_c [3];
    logic signed [Q_W-1:0] r_s [3];
    logic signed [Q_W-1:0] n_c [3];
    logic signed [Q_W-1:0] n_s [3];

    logic signed [P_W-1:0] r_cycp, r_cysp, r_sycp, r_sysp, r_cpsr, r_cpcr;
    logic signed [P_W-1:0] r_sycr, r_sysr, r_cycr, r_cysr;
    logic signed [Q_W-1:0] r_sp1, r_sr1, r_cr1;

    logic signed [P_W-1:0] r_t01, r_t02, r_t11, r_t12;
    logic signed [P_W-1:0] r_sycr2, r_sysr2, r_cycr2, r_cysr2;
    logic signed [P_W-1:0] r_cycp2, r_sycp2, r_cpsr2, r_cpcr2;
    logic signed [Q_W-1:0] r_sp2;

    logic [NUM_OUT-1:0][FIELD_W-1:0] r_fields;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign w_rdy0  = !r_v0 || w_rdy1;
    assign o_ready = w_rdy0;
    assign o_valid = r_v3;
    assign o_fields = r_fields;

    always_comb begin
        logic signed [XY_W-1:0] cx;
        logic signed [XY_W-1:0] sy;
        for (int k = 0; k < 3; k++) begin
            cx = (i_lane[k].x + XY_W'(2)) >>> 2;
            sy = (i_lane[k].y + XY_W'(2)) >>> 2;
            if (i_lane[k].flip) begin
                cx = -cx;
                sy = -sy;
            end
            n_c[k] = cx[Q_W-1:0];
            n_s[k] = sy[Q_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= i_valid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_valid) begin
            r_c <= n_c;
            r_s <= n_s;
        end
        if (w_rdy1 && r_v0) begin
            r_cycp <= mulq(r_c[0], r_c[1]);
            r_cysp <= mulq(r_c[0], r_s[1]);
            r_sycp <= mulq(r_s[0], r_c[1]);
            r_sysp <= mulq(r_s[0], r_s[1]);
            r_cpsr <= mulq(r_c[1], r_s[2]);
            r_cpcr <= mulq(r_c[1], r_c[2]);
            r_sycr <= mulq(r_s[0], r_c[2]);
            r_sysr <= mulq(r_s[0], r_s[2]);
            r_cycr <= mulq(r_c[0], r_c[2]);
            r_cysr <= mulq(r_c[0], r_s[2]);
            r_sp1  <= r_s[1];
            r_sr1  <= r_s[2];
            r_cr1  <= r_c[2];
        end
        if (w_rdy2 && r_v1) begin
            r_t01   <= mulq(r_cysp[Q_W-1:0], r_sr1);
            r_t02   <= mulq(r_cysp[Q_W-1:0], r_cr1);
            r_t11   <= mulq(r_sysp[Q_W-1:0], r_sr1);
            r_t12   <= mulq(r_sysp[Q_W-1:0], r_cr1);
            r_sycr2 <= r_sycr;
            r_sysr2 <= r_sysr;
            r_cycr2 <= r_cycr;
            r_cysr2 <= r_cysr;
            r_cycp2 <= r_cycp;
            r_sycp2 <= r_sycp;
            r_cpsr2 <= r_cpsr;
            r_cpcr2 <= r_cpcr;
            r_sp2   <= r_sp1;
        end
        if (w_rdy3 && r_v2) begin
            r_fields[0] <= to_field((P_W+2)'(r_cycp2));
            r_fields[1] <= to_field((P_W+2)'(r_t01) - (P_W+2)'(r_sycr2));
            r_fields[2] <= to_field((P_W+2)'(r_t02) + (P_W+2)'(r_sysr2));
            r_fields[3] <= to_field((P_W+2)'(r_sycp2));
            r_fields[4] <= to_field((P_W+2)'(r_t11) + (P_W+2)'(r_cycr2));
            r_fields[5] <= to_field((P_W+2)'(r_t12) - (P_W+2)'(r_cysr2));
            r_fields[6] <= to_field(-((P_W+2)'(r_sp2)));
            r_fields[7] <= to_field((P_W+2)'(r_cpsr2));
            r_fields[8] <= to_field((P_W+2)'(r_cpcr2));
        end
    end
endmodule

// ===== sv/euler_to_rotation_matrix_top.sv =====
// Path: an input register, the chain of CORDIC cells, then the four matrix stages.
// Throughput: one request per cycle, set by the fully pipelined chain of CORDIC cells
// and the four matrix stages; each stage stalls only when its successor is full.
// Reset: synchronous, active low; clears every stage valid bit, drops requests in flight.
// The data registers are not reset; the block keeps no other state.
`include "euler_to_rotation_matrix_top_assert.svh"
module euler_to_rotation_matrix_top import ertm_pkg::*; #(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
    parameter int FRAC_BITS     = DEF_FRAC_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // yaw_angle [15:0], pitch_angle [31:16], roll_angle [47:32]
    input  logic [47:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // m00 [15:0], m01, m02, m10, m11, m12, m20, m21, m22 [143:128]
    output logic [143:0] m_axis_tdata
);
    localparam int NSTAGE = (CORDIC_STAGES > ATAN_COUNT) ? ATAN_COUNT :
                            ((CORDIC_STAGES < 1) ? 1 : CORDIC_STAGES);
    localparam logic signed [XY_W-1:0] GAIN = start_gain(NSTAGE);
    localparam logic signed [16:0] OUT_LIM = 17'(1 <<< FRAC_BITS);

    logic  r_v0;
    t_lane r_lane0 [3];
    t_lane n_lane0 [3];

    logic  w_valid [NSTAGE+1];
    logic  w_ready [NSTAGE+1];
    t_lane w_lane  [NSTAGE+1][3];
    logic [NUM_OUT-1:0][FIELD_W-1:0] w_fields;
    logic  w_in_range;

    always_comb begin
        logic signed [17:0] r;
        logic               flip;
        for (int k = 0; k < 3; k++) begin
            r = 18'(signed'(s_axis_tdata[16*k +: 16]));
            flip = 1'b0;
            if (r > HALF_UNITS) begin
                r = r - 18'(TURN_UNITS);
            end else if (r < -(HALF_UNITS - 1)) begin
                r = r + 18'(TURN_UNITS);
            end
            if (r > QUARTER_UNITS) begin
                r = r - 18'(HALF_UNITS);
                flip = 1'b1;
            end else if (r < -QUARTER_UNITS) begin
                r = r + 18'(HALF_UNITS);
                flip = 1'b1;
            end
            n_lane0[k].x    = GAIN;
            n_lane0[k].y    = '0;
            n_lane0[k].z    = Z_W'(r) <<< ANGLE_SHIFT;
            n_lane0[k].flip = flip;
        end
    end

    assign s_axis_tready = !r_v0 || w_ready[0];
    assign w_valid[0] = r_v0;
    assign w_lane[0]  = r_lane0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (s_axis_tready) begin
            r_v0 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_lane0 <= n_lane0;
        end
    end

    for (genvar g = 0; g < NSTAGE; g++) begin : g_cell
        ertm_cordic_cell #(
            .SHIFT (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_lane  (w_lane[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    ertm_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[NSTAGE]),
        .o_ready  (w_ready[NSTAGE]),
        .i_lane   (w_lane[NSTAGE]),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_fields (w_fields)
    );

    assign m_axis_tdata = w_fields;

    always_comb begin
        logic signed [16:0] f;
        w_in_range = 1'b1;
        for (int k = 0; k < NUM_OUT; k++) begin
            f = 17'(signed'(w_fields[k]));
            if (f > OUT_LIM || f < -OUT_LIM) begin
                w_in_range = 1'b0;
            end
        end
        if (FRAC_BITS >= FIELD_W - 1) begin
            w_in_range = 1'b1;
        end
    end

    `ERTM_ASSERT_NEXT(a_entry_fills, s_axis_tvalid && s_axis_tready, r_v0)
    `ERTM_ASSERT(a_entry_free, !r_v0 |-> s_axis_tready)
    `ERTM_ASSERT(a_out_range, m_axis_tvalid |-> w_in_range)
endmodule
